// ===== design/lpht_pkg.sv =====
package lpht_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_BYTES = 8;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 9;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int SIZE_W   = SLOT_W + 1;
    localparam int SUM_W    = 8 + $clog2(KEY_BYTES + 1);
    localparam int DIVCNT_W = $clog2(SUM_W);

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_PROBE = 5'b00100,
        S_DONE  = 5'b01000,
        S_SPARE = 5'b10000
    } t_state;

    typedef struct packed {
        logic             deleted;
        logic             busy;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    function automatic logic [SUM_W-1:0] key_sum(input logic [KEY_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            s = s + SUM_W'(k[8*b +: 8]);
        end
        return s;
    endfunction

endpackage

// ===== design/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/linear_probe_hash_table_unit.sv =====
// Open-addressing hash table, linear probing with tombstones.
// Request channel (i_in_valid / o_in_stall): command, key, value. A request is
// taken only while the unit is idle; o_in_stall is high from acceptance until
// the result has been moved into the output register.
// Result channel (o_out_valid / i_out_stall): status, slot, found_value, one
// result per request, held steady while i_out_stall is high. The unit takes
// the next request while a result still waits in the output register.
// A bit-serial modulo gives the home slot, then the probe reads one slot
// per cycle from the slot RAM, whose read data is registered, and the
// result is then moved into the output register.
// The next request is taken once the result is in the output register.
// The probe loop is bound by the single read port of the slot RAM, which is
// read once per slot. A stalled result holds the unit in its last state.
// i_cfg_we / i_cfg_data write the table size (0 acts as 1, above 256 as 256);
// write it only while idle. Entries are not cleared or rehashed on a change.
// Reset (i_rst_n low, synchronous) empties the table at once through per-slot
// valid bits and sets the size to 256; no clearing pass is needed.
module linear_probe_hash_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lpht_pkg::CMD_W-1:0]    i_in_command,
    input  logic [lpht_pkg::KEY_W-1:0]    i_in_key,
    input  logic [lpht_pkg::VAL_W-1:0]    i_in_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lpht_pkg::STAT_W-1:0]   o_out_status,
    output logic [lpht_pkg::SLOT_W-1:0]   o_out_slot,
    output logic [lpht_pkg::VAL_W-1:0]    o_out_found_value,
    input  logic                          i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]    i_cfg_data
);

    import lpht_pkg::*;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_value;
    logic [SUM_W-1:0]    r_sum;
    logic [SIZE_W-1:0]   r_rem;
    logic [DIVCNT_W-1:0] r_div_cnt;
    logic [SIZE_W-1:0]   r_tsize;
    logic [CAPACITY-1:0] r_slot_vld;

    logic [SLOT_W-1:0]   r_iss_addr;
    logic [SIZE_W-1:0]   r_iss_cnt;
    logic                r_chk_vld;
    logic [SLOT_W-1:0]   r_chk_addr;
    logic                r_chk_last;
    logic                r_chk_ent_vld;

    t_status             r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic [VAL_W-1:0]    r_res_fv;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [VAL_W-1:0]    r_out_fv;

    logic                in_accept;
    logic                out_free;
    logic [SIZE_W-1:0]   div_trial;
    logic [SIZE_W-1:0]   n_rem;
    logic                div_last;
    logic                iss_en;
    logic [SLOT_W-1:0]   n_iss_addr;
    logic [SIZE_W-1:0]   cfg_size;

    t_entry              rd_ent;
    t_entry              wr_ent;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic                e_busy;
    logic                e_del;
    logic                resolve;
    logic                ram_we;
    t_status             res_status;
    logic [VAL_W-1:0]    res_fv;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // bit-serial remainder of the key byte sum by the table size
    assign div_trial = {r_rem[SIZE_W-2:0], r_sum[SUM_W-1]};
    assign n_rem     = (div_trial >= r_tsize) ? div_trial - r_tsize : div_trial;
    assign div_last  = (r_div_cnt == DIVCNT_W'(SUM_W - 1));

    assign n_iss_addr = (({1'b0, r_iss_addr} + 1'b1) == r_tsize) ? '0 : r_iss_addr + 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_size = SIZE_W'(1);
        end else if (i_cfg_data > CFG_W'(CAPACITY)) begin
            cfg_size = SIZE_W'(CAPACITY);
        end else begin
            cfg_size = SIZE_W'(i_cfg_data);
        end
    end

    assign rd_ent = t_entry'(ram_rdata);
    assign e_busy = r_chk_ent_vld && rd_ent.busy;
    assign e_del  = r_chk_ent_vld && rd_ent.deleted;

    always_comb begin
        resolve    = 1'b0;
        ram_we     = 1'b0;
        wr_ent     = rd_ent;
        res_status = ST_NOT_FOUND;
        res_fv     = '0;
        if (r_state == S_PROBE && r_chk_vld) begin
            if (r_cmd == CMD_INSERT) begin
                if (!e_busy || e_del) begin
                    resolve        = 1'b1;
                    ram_we         = 1'b1;
                    res_status     = ST_OK;
                    wr_ent.key     = r_key;
                    wr_ent.value   = r_value;
                    wr_ent.busy    = 1'b1;
                    wr_ent.deleted = 1'b0;
                end else if (r_chk_last) begin
                    resolve    = 1'b1;
                    res_status = ST_FULL;
                end
            end else if (!e_busy && !e_del) begin
                resolve = 1'b1;
            end else if (e_busy && !e_del && rd_ent.key == r_key) begin
                resolve    = 1'b1;
                res_status = ST_OK;
                case (r_cmd)
                    CMD_FIND: begin
                        res_fv = rd_ent.value;
                    end
                    CMD_DELETE: begin
                        ram_we         = 1'b1;
                        wr_ent.busy    = 1'b0;
                        wr_ent.deleted = 1'b1;
                    end
                    CMD_UPDATE: begin
                        ram_we       = 1'b1;
                        wr_ent.value = r_value;
                    end
                    default: begin
                    end
                endcase
            end else if (r_chk_last) begin
                resolve = 1'b1;
            end
        end
    end

    // next read goes out while the previous one is checked; no further read
    // goes out once the probe resolves
    assign iss_en = (r_state == S_PROBE) && (r_iss_cnt < r_tsize) && !resolve;

    lpht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_chk_addr),
        .i_wdata (wr_ent),
        .i_re    (iss_en),
        .i_raddr (r_iss_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tsize     <= SIZE_W'(CAPACITY);
            r_slot_vld  <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tsize <= cfg_size;
            end
            if (ram_we) begin
                r_slot_vld[r_chk_addr] <= 1'b1;
            end
            r_chk_vld <= iss_en;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (div_last) begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (resolve) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr    <= r_iss_addr;
        r_chk_last    <= (r_iss_cnt == r_tsize - 1'b1);
        r_chk_ent_vld <= r_slot_vld[r_iss_addr];
        if (r_state == S_IDLE && in_accept) begin
            r_cmd     <= t_cmd'(i_in_command);
            r_key     <= i_in_key & KEY_MASK;
            r_value   <= i_in_value;
            r_sum     <= key_sum(i_in_key & KEY_MASK);
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (r_state == S_HASH) begin
            r_rem     <= n_rem;
            r_sum     <= {r_sum[SUM_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + 1'b1;
            if (div_last) begin
                r_iss_addr <= n_rem[SLOT_W-1:0];
                r_iss_cnt  <= '0;
            end
        end
        if (iss_en) begin
            r_iss_addr <= n_iss_addr;
            r_iss_cnt  <= r_iss_cnt + 1'b1;
        end
        if (resolve) begin
            r_res_status <= res_status;
            r_res_slot   <= (res_status == ST_OK) ? r_chk_addr : '0;
            r_res_fv     <= res_fv;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_fv     <= r_res_fv;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_slot        = r_out_slot;
    assign o_out_found_value = r_out_fv;

    a_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_PROBE))
        else $error("slot RAM written outside probe");

    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_HASH))
        else $error("accepted request did not start hashing");

    a_chk_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_state == S_PROBE))
        else $error("probe read returned outside probe");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status != ST_OK) |->
            (o_out_slot == '0 && o_out_found_value == '0))
        else $error("failed request carries slot or value");

endmodule
